// File: hw/rtl/advance_decline_breadth_macros.svh
// Assertion macros shared by the breadth tracker RTL.
// Each macro checks one implication on the rising clock edge, with the
// active-low reset disabling the check.
`ifndef ADVANCE_DECLINE_BREADTH_MACROS_SVH
`define ADVANCE_DECLINE_BREADTH_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ABD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ABD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ABD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define ABD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/abd_pkg.sv
`timescale 1ns / 1ps

package abd_pkg;

  // Fixed field widths of the transactions.
  localparam int IDX_W     = 10;
  localparam int CLOSE_W   = 32;
  localparam int BREADTH_W = 12;
  localparam int CLASS_W   = 2;

  // Default sizing of the symbol table.
  localparam int NUM_SYMBOLS_DEF = 1024;
  localparam int PRICE_WIDTH_DEF = 32;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Function codes of an input transaction.
  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // Tick classes.
  typedef enum logic [CLASS_W-1:0] {
    CLS_FLAT = 2'd0,
    CLS_UP   = 2'd1,
    CLS_DOWN = 2'd2
  } tick_class_e;

  // Operation decided by the front part.
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SKIP   = 2'd2
  } op_kind_e;

  // Input transaction payload.
  typedef struct packed {
    logic                      func;
    logic [IDX_W-1:0]          symbol_index;
    logic signed [CLOSE_W-1:0] close_price;
    logic                      update_is_add;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [BREADTH_W-1:0] breadth_value;
    logic [CLASS_W-1:0]          tick_class;
  } out_item_t;

  // Classified item held in the queue.
  typedef struct packed {
    op_kind_e                  op;
    logic [IDX_W-1:0]          symbol_index;
    logic signed [CLOSE_W-1:0] close_price;
    logic                      update_is_add;
  } q_entry_t;

  // Status the back part reports to the front part.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// File: hw/rtl/abd_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction.
interface abd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/abd_front.sv
`timescale 1ns / 1ps

// Front part: accepts input transactions and classifies them for the back part.
module abd_front import abd_pkg::*; #(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
  abd_stream_if.sink  in_i,
  input  back_status_t status_i,
  input  logic         q_ready_i,
  output logic         q_push_o,
  output q_entry_t     q_entry_o
);

  logic in_range;

  // Accept whenever the queue has room and the table is not being cleared.
  assign in_i.ready = q_ready_i && !status_i.clearing;
  assign q_push_o   = in_i.valid && in_i.ready;

  // Symbols past the end of the table are carried through untouched.
  assign in_range = 32'(in_i.payload.symbol_index) < 32'(NUM_SYMBOLS);

  always_comb begin
    q_entry_o.symbol_index  = in_i.payload.symbol_index;
    q_entry_o.close_price   = in_i.payload.close_price;
    q_entry_o.update_is_add = in_i.payload.update_is_add;
    if (!in_range) begin
      q_entry_o.op = OP_SKIP;
    end else if (in_i.payload.func == FUNC_INIT) begin
      q_entry_o.op = OP_INIT;
    end else begin
      q_entry_o.op = OP_UPDATE;
    end
  end

endmodule

// File: hw/rtl/abd_queue.sv
`timescale 1ns / 1ps
`include "advance_decline_breadth_macros.svh"

// Short queue decoupling the front part from the back part.
module abd_queue import abd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     ready_o,
  output logic     valid_o,
  output q_entry_t head_o,
  input  logic     pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `ABD_ASSERT_IMP(a_q_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
  `ABD_ASSERT_IMP(a_q_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0, "pop from empty queue")

endmodule

// File: hw/rtl/abd_back.sv
`timescale 1ns / 1ps
`include "advance_decline_breadth_macros.svh"

// Back part: read-modify-write of the symbol table, breadth totals and result
// register.
module abd_back import abd_pkg::*; #(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  q_entry_t     q_head_i,
  output logic         q_pop_o,
  output back_status_t status_o,
  abd_stream_if.source out_o
);

  localparam int AW     = $clog2(NUM_SYMBOLS);
  localparam int CW     = $clog2(NUM_SYMBOLS + 1);
  localparam int DW     = (CW > BREADTH_W) ? CW : BREADTH_W;
  localparam int WORD_W = PRICE_WIDTH + 3;
  localparam int SEEN_B = 2;

  // Table word: previous close, seen flag, last tick class.
  logic [WORD_W-1:0] sym_mem_q [NUM_SYMBOLS];
  logic [WORD_W-1:0] rd_q;

  // Clearing pass after reset.
  logic              clr_busy_q;
  logic [AW-1:0]     clr_idx_q;

  // Execute stage.
  logic                   s1_valid_q;
  op_kind_e               s1_op_q;
  logic [AW-1:0]          s1_addr_q;
  logic [PRICE_WIDTH-1:0] s1_price_q;
  logic                   s1_add_q;
  logic                   byp_hit_q, byp_hit_d;
  logic [WORD_W-1:0]      byp_word_q;

  // Totals and result register.
  logic [CW-1:0]     adv_q, adv_d;
  logic [CW-1:0]     dec_q, dec_d;
  logic              out_valid_q;
  out_item_t         out_q;

  logic                   exec;
  logic [AW-1:0]          rd_addr;
  logic [WORD_W-1:0]      word;
  logic [PRICE_WIDTH-1:0] prev_price;
  logic                   seen;
  logic [CLASS_W-1:0]     old_cls;
  tick_class_e            new_cls;
  logic [WORD_W-1:0]      new_word;
  logic                   inc_up, dec_up, inc_dn, dec_dn;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic [DW-1:0]          diff;

  assign status_o.clearing = clr_busy_q;

  // Handshake between queue, execute stage and result register.
  assign exec    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign q_pop_o = q_valid_i && !clr_busy_q && (!s1_valid_q || exec);
  assign rd_addr = AW'(q_head_i.symbol_index);

  // Entry as seen by the executing item, with the last write forwarded.
  assign word       = byp_hit_q ? byp_word_q : rd_q;
  assign prev_price = word[WORD_W-1:3];
  assign seen       = word[SEEN_B];
  assign old_cls    = word[CLASS_W-1:0];

  // Classify the tick and build the updated table word.
  always_comb begin
    new_cls  = CLS_FLAT;
    new_word = word;
    if (s1_op_q == OP_UPDATE) begin
      if ($signed(s1_price_q) > $signed(prev_price)) begin
        new_cls = CLS_UP;
      end else if ($signed(s1_price_q) < $signed(prev_price)) begin
        new_cls = CLS_DOWN;
      end
      new_word = {(s1_add_q ? s1_price_q : prev_price), 1'b1, new_cls};
    end else if (s1_op_q == OP_INIT) begin
      new_word = {s1_price_q, seen, old_cls};
    end
  end

  // A symbol leaves its old class and joins the new one.
  always_comb begin
    inc_up = 1'b0;
    dec_up = 1'b0;
    inc_dn = 1'b0;
    dec_dn = 1'b0;
    if (exec && s1_op_q == OP_UPDATE) begin
      inc_up = new_cls == CLS_UP && !(seen && old_cls == CLS_UP);
      inc_dn = new_cls == CLS_DOWN && !(seen && old_cls == CLS_DOWN);
      dec_up = seen && old_cls == CLS_UP && new_cls != CLS_UP;
      dec_dn = seen && old_cls == CLS_DOWN && new_cls != CLS_DOWN;
    end
    adv_d = adv_q + CW'(inc_up) - CW'(dec_up);
    dec_d = dec_q + CW'(inc_dn) - CW'(dec_dn);
    diff  = DW'(adv_d) - DW'(dec_d);
  end

  // Single write port: clearing pass or the executing item.
  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = exec && s1_op_q != OP_SKIP;
      mem_waddr = s1_addr_q;
      mem_wdata = new_word;
    end
  end

  assign byp_hit_d = mem_we && mem_waddr == rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sym_mem_q[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd_q <= sym_mem_q[rd_addr];
    end
  end

  // Clearing pass over the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == AW'(NUM_SYMBOLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Execute stage control, totals and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      adv_q       <= '0;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (exec) begin
        s1_valid_q <= 1'b0;
      end
      adv_q <= adv_d;
      dec_q <= dec_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Execute stage payload and result payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_op_q    <= q_head_i.op;
      s1_addr_q  <= rd_addr;
      s1_price_q <= PRICE_WIDTH'(q_head_i.close_price);
      s1_add_q   <= q_head_i.update_is_add;
      byp_hit_q  <= byp_hit_d;
      byp_word_q <= mem_wdata;
    end
    if (exec) begin
      out_q.breadth_value <= diff[BREADTH_W-1:0];
      out_q.tick_class    <= new_cls;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `ABD_ASSERT_IMP(a_no_item_while_clearing, clk_i, rst_ni, clr_busy_q, !s1_valid_q && !q_pop_o, "item in flight during clearing pass")
  `ABD_ASSERT_IMP(a_totals_bound, clk_i, rst_ni, 1'b1, (CW+1)'(adv_q) + (CW+1)'(dec_q) <= (CW+1)'(NUM_SYMBOLS), "totals exceed symbol count")
  `ABD_ASSERT_NXT(a_init_keeps_totals, clk_i, rst_ni, exec && s1_op_q != OP_UPDATE, adv_q == $past(adv_q) && dec_q == $past(dec_q), "totals changed without an update")

endmodule

// File: hw/rtl/advance_decline_breadth.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload     Fields
// in_i     in   in_item_t   func, symbol_index, close_price, update_is_add
// out_o    out  out_item_t  breadth_value, tick_class
//
// Sustains one transaction per cycle each way but for out_o stalls and the
// clearing pass; a result passes a queue slot, the execute stage and the
// result register. The rate rests on one table read and one table write a
// cycle, the word written in the previous cycle forwarded to the item that
// reads it next. After reset the table is cleared with in_i.ready low. A
// stalled out_o holds the result register; the queue takes up the slack.
module advance_decline_breadth import abd_pkg::*; #(
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  abd_stream_if.sink   in_i,
  abd_stream_if.source out_o
);

  back_status_t status;
  logic         q_ready;
  logic         q_push;
  q_entry_t     q_entry;
  logic         q_valid;
  q_entry_t     q_head;
  logic         q_pop;

  abd_front #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_front (
    .in_i     (in_i),
    .status_i (status),
    .q_ready_i(q_ready),
    .q_push_o (q_push),
    .q_entry_o(q_entry)
  );

  abd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  abd_back #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .PRICE_WIDTH(PRICE_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule
